>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked with a synchronous active-low
// reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

>>> src/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Types, codes and constants of the checksummed parameter table.
// ----------------------------------------------------------------------------
package cpt_pkg;

    // default geometry
    localparam int unsigned TABLE_DEPTH_DEF  = 64;
    localparam int unsigned SUM_LOW_POS_DEF  = 60;
    localparam int unsigned SUM_HIGH_POS_DEF = 61;
    localparam int unsigned CRC_POS_DEF      = 62;

    // transaction kinds
    localparam logic [2:0] K_RD_BYTE = 3'd0;
    localparam logic [2:0] K_WR_BYTE = 3'd1;
    localparam logic [2:0] K_RD_HALF = 3'd2;
    localparam logic [2:0] K_WR_HALF = 3'd3;
    localparam logic [2:0] K_UPDATE  = 3'd4;
    localparam logic [2:0] K_VERIFY  = 3'd5;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_SUM_BAD = 2'd2;
    localparam logic [1:0] ST_CRC_BAD = 2'd3;

    // check unit operations
    localparam logic [2:0] OP_NOP      = 3'd0;
    localparam logic [2:0] OP_INIT_SUM = 3'd1;
    localparam logic [2:0] OP_INIT_CRC = 3'd2;
    localparam logic [2:0] OP_ADD      = 3'd3;
    localparam logic [2:0] OP_CRC      = 3'd4;

    // CRC-16/MODBUS, reflected
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  address;
        logic [15:0] write_value;
    } t_in;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
    } t_chk_ctl;

    // power-on contents; everything not listed is zero
    function automatic logic [7:0] cpt_default_byte(input logic [7:0] a);
        logic [7:0] v;
        case (a)
            8'd0:    v = 8'd58;
            8'd1:    v = 8'd55;
            8'd3:    v = 8'd1;
            8'd4:    v = 8'd1;
            8'd7:    v = 8'd1;
            8'd9:    v = 8'd24;
            8'd10:   v = 8'd7;
            8'd11:   v = 8'd23;
            8'd12:   v = 8'd12;
            8'd15:   v = 8'd1;
            8'd16:   v = 8'd40;
            8'd20:   v = 8'd40;
            8'd21:   v = 8'd1;
            8'd22:   v = 8'd164;
            8'd23:   v = 8'd164;
            8'd27:   v = 8'd8;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // one byte through the CRC, LSB first
    function automatic logic [15:0] cpt_crc_byte(input logic [15:0] crc,
                                                 input logic [7:0]  d);
        logic [15:0] c;
        c = crc ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/checksummed_parameter_table_top.sv
// ----------------------------------------------------------------------------
// checksummed_parameter_table_top
// Byte-wide parameter store with bounds-checked byte/halfword access and
// sum + CRC-16/MODBUS protection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command
//   transaction: read/write byte, read/write little-endian halfword, update
//   checks, or verify. Every command yields exactly one result transaction on
//   the output channel (o_out_valid / i_out_stall / o_out_data).
//   Commands are handled one at a time by a small sequencer around a single
//   RAM port (one byte per cycle) and one shared sum/CRC accumulator.
//   Reads and writes move one byte per state; an out-of-range or unused
//   kind goes straight to the result. Update sums the bytes below
//   SUM_LOW_POS, writes both sum bytes, then runs the bytes below CRC_POS
//   through the CRC and writes its low byte; verify compares both stored
//   checks instead and stops at a sum mismatch.
//   The next command is taken in the cycle after the result is loaded.
//   The result sits in an output register; a new command is accepted while
//   it waits, but the sequencer holds its next result until the register
//   drains, so a stalled receiver eventually stalls the input.
//   Reset clears per-entry valid bits at once: unwritten entries read as the
//   default parameter table, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module checksummed_parameter_table_top #(
    parameter int unsigned TABLE_DEPTH  = cpt_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned SUM_LOW_POS  = cpt_pkg::SUM_LOW_POS_DEF,
    parameter int unsigned SUM_HIGH_POS = cpt_pkg::SUM_HIGH_POS_DEF,
    parameter int unsigned CRC_POS      = cpt_pkg::CRC_POS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cpt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cpt_pkg::t_out o_out_data
);
    import cpt_pkg::*;

    // storage must also cover the check positions
    localparam int unsigned POS_MAX_A   = (SUM_LOW_POS > SUM_HIGH_POS) ?
                                          SUM_LOW_POS : SUM_HIGH_POS;
    localparam int unsigned POS_MAX     = (POS_MAX_A > CRC_POS) ? POS_MAX_A : CRC_POS;
    localparam int unsigned STORE_DEPTH = (TABLE_DEPTH > POS_MAX + 1) ?
                                          TABLE_DEPTH : POS_MAX + 1;
    localparam int unsigned AW          = $clog2(STORE_DEPTH);

    // sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RD1      = 5'd1;   // issue first read
    localparam logic [4:0] S_RD2      = 5'd2;   // take low byte, maybe issue high
    localparam logic [4:0] S_RDHI     = 5'd3;   // take high byte
    localparam logic [4:0] S_WR1      = 5'd4;
    localparam logic [4:0] S_WR2      = 5'd5;
    localparam logic [4:0] S_SUM      = 5'd6;   // walk bytes into the sum
    localparam logic [4:0] S_WSUMLO   = 5'd7;
    localparam logic [4:0] S_WSUMHI   = 5'd8;
    localparam logic [4:0] S_CRC      = 5'd9;   // walk bytes into the CRC
    localparam logic [4:0] S_WCRC     = 5'd10;
    localparam logic [4:0] S_VSUMLO   = 5'd11;
    localparam logic [4:0] S_VSUMHI   = 5'd12;
    localparam logic [4:0] S_VSUMCMP  = 5'd13;
    localparam logic [4:0] S_VCRC     = 5'd14;
    localparam logic [4:0] S_VCRCCMP  = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    // control
    logic [4:0]  r_state, n_state;
    logic        r_feed,  n_feed;      // read data of last cycle goes to the unit
    logic        r_out_vld, n_out_vld;
    logic [STORE_DEPTH-1:0] r_valid;   // entry written since reset

    // transaction context
    logic [AW-1:0] r_addr,  n_addr;
    logic [15:0]   r_wdata, n_wdata;
    logic          r_half,  n_half;
    logic          r_verify, n_verify;
    logic [AW-1:0] r_idx,   n_idx;
    logic [15:0]   r_res_data, n_res_data;
    logic [1:0]    r_res_status, n_res_status;
    logic [7:0]    r_cmp_lo, n_cmp_lo;
    t_out          r_out, n_out;

    // memory
    logic [7:0]    mem [STORE_DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_rd_vbit;
    logic [7:0]    r_rd_dflt;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_byte;

    logic          in_acc;
    logic          byte_ok, half_ok;
    t_chk_ctl      chk_ctl;
    logic [15:0]   chk_acc;

    cpt_chk_unit u_chk (
        .i_clk (i_clk),
        .i_ctl (chk_ctl),
        .o_acc (chk_acc)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // unwritten entries read back as the power-on table
    assign rd_byte = r_rd_vbit ? r_rd_data : r_rd_dflt;

    assign byte_ok = ({1'b0, i_in_data.address} < 9'(TABLE_DEPTH));
    assign half_ok = (({1'b0, i_in_data.address} + 9'd1) < 9'(TABLE_DEPTH));

    always_comb begin
        n_state      = r_state;
        n_feed       = 1'b0;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out        = r_out;
        n_addr       = r_addr;
        n_wdata      = r_wdata;
        n_half       = r_half;
        n_verify     = r_verify;
        n_idx        = r_idx;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_cmp_lo     = r_cmp_lo;
        rd_en        = 1'b0;
        rd_addr      = r_addr;
        wr_en        = 1'b0;
        wr_addr      = r_addr;
        wr_data      = r_wdata[7:0];
        chk_ctl.op        = OP_NOP;
        chk_ctl.data_byte = rd_byte;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_addr       = i_in_data.address[AW-1:0];
                    n_wdata      = i_in_data.write_value;
                    n_res_data   = '0;
                    n_res_status = ST_OK;
                    n_idx        = '0;
                    n_state      = S_DONE;
                    case (i_in_data.kind)
                        K_RD_BYTE, K_WR_BYTE: begin
                            n_half = 1'b0;
                            if (!byte_ok) begin
                                n_res_status = ST_RANGE;
                            end else if (i_in_data.kind == K_RD_BYTE) begin
                                n_state = S_RD1;
                            end else begin
                                n_state = S_WR1;
                            end
                        end
                        K_RD_HALF, K_WR_HALF: begin
                            n_half = 1'b1;
                            if (!half_ok) begin
                                n_res_status = ST_RANGE;
                            end else if (i_in_data.kind == K_RD_HALF) begin
                                n_state = S_RD1;
                            end else begin
                                n_state = S_WR1;
                            end
                        end
                        K_UPDATE, K_VERIFY: begin
                            n_verify   = (i_in_data.kind == K_VERIFY);
                            chk_ctl.op = OP_INIT_SUM;
                            n_state    = S_SUM;
                        end
                        default: n_state = S_DONE;   // unused kinds: ok, no effect
                    endcase
                end
            end
            S_RD1: begin
                rd_en   = 1'b1;
                rd_addr = r_addr;
                n_state = S_RD2;
            end
            S_RD2: begin
                n_res_data = {8'h00, rd_byte};
                if (r_half) begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr + AW'(1);
                    n_state = S_RDHI;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RDHI: begin
                n_res_data = {rd_byte, r_res_data[7:0]};
                n_state    = S_DONE;
            end
            S_WR1: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = r_wdata[7:0];
                n_state = r_half ? S_WR2 : S_DONE;
            end
            S_WR2: begin
                wr_en   = 1'b1;
                wr_addr = r_addr + AW'(1);
                wr_data = r_wdata[15:8];
                n_state = S_DONE;
            end
            S_SUM: begin
                if (r_feed) begin
                    chk_ctl.op = OP_ADD;
                end
                if (r_idx != AW'(SUM_LOW_POS)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx;
                    n_feed  = 1'b1;
                    n_idx   = r_idx + AW'(1);
                end else begin
                    n_state = r_verify ? S_VSUMLO : S_WSUMLO;
                end
            end
            S_WSUMLO: begin
                wr_en   = 1'b1;
                wr_addr = AW'(SUM_LOW_POS);
                wr_data = chk_acc[7:0];
                n_state = S_WSUMHI;
            end
            S_WSUMHI: begin
                wr_en      = 1'b1;
                wr_addr    = AW'(SUM_HIGH_POS);
                wr_data    = chk_acc[15:8];
                n_idx      = '0;
                chk_ctl.op = OP_INIT_CRC;
                n_state    = S_CRC;
            end
            S_CRC: begin
                if (r_feed) begin
                    chk_ctl.op = OP_CRC;
                end
                if (r_idx != AW'(CRC_POS)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx;
                    n_feed  = 1'b1;
                    n_idx   = r_idx + AW'(1);
                end else begin
                    n_state = r_verify ? S_VCRC : S_WCRC;
                end
            end
            S_WCRC: begin
                wr_en   = 1'b1;
                wr_addr = AW'(CRC_POS);
                wr_data = chk_acc[7:0];
                n_state = S_DONE;
            end
            S_VSUMLO: begin
                rd_en   = 1'b1;
                rd_addr = AW'(SUM_LOW_POS);
                n_state = S_VSUMHI;
            end
            S_VSUMHI: begin
                n_cmp_lo = rd_byte;
                rd_en    = 1'b1;
                rd_addr  = AW'(SUM_HIGH_POS);
                n_state  = S_VSUMCMP;
            end
            S_VSUMCMP: begin
                if ({rd_byte, r_cmp_lo} != chk_acc) begin
                    n_res_status = ST_SUM_BAD;
                    n_state      = S_DONE;
                end else begin
                    n_idx      = '0;
                    chk_ctl.op = OP_INIT_CRC;
                    n_state    = S_CRC;
                end
            end
            S_VCRC: begin
                rd_en   = 1'b1;
                rd_addr = AW'(CRC_POS);
                n_state = S_VCRCCMP;
            end
            S_VCRCCMP: begin
                if (rd_byte != chk_acc[7:0]) begin
                    n_res_status = ST_CRC_BAD;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to be free
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld       = 1'b1;
                    n_out.read_data = r_res_data;
                    n_out.status    = r_res_status;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_feed    <= 1'b0;
            r_out_vld <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_feed    <= n_feed;
            r_out_vld <= n_out_vld;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // context and result registers
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_wdata      <= n_wdata;
        r_half       <= n_half;
        r_verify     <= n_verify;
        r_idx        <= n_idx;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_cmp_lo     <= n_cmp_lo;
        r_out        <= n_out;
    end

    // single-port store, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vbit <= r_valid[rd_addr];
            r_rd_dflt <= cpt_default_byte(8'(rd_addr));
        end
    end

endmodule

>>> src/cpt_chk_unit.sv
// ----------------------------------------------------------------------------
// cpt_chk_unit
// Shared check accumulator: 16-bit wrapping byte sum or CRC-16/MODBUS,
// one byte per cycle.
// ----------------------------------------------------------------------------
module cpt_chk_unit (
    input  logic              i_clk,
    input  cpt_pkg::t_chk_ctl i_ctl,
    output logic [15:0]       o_acc
);
    import cpt_pkg::*;

    logic [15:0] r_acc;
    logic [15:0] n_acc;

    always_comb begin
        case (i_ctl.op)
            OP_INIT_SUM: n_acc = '0;
            OP_INIT_CRC: n_acc = CRC_INIT;
            OP_ADD:      n_acc = r_acc + {8'h00, i_ctl.data_byte};
            OP_CRC:      n_acc = cpt_crc_byte(r_acc, i_ctl.data_byte);
            default:     n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

>>> src/cpt_checker.sv
// ----------------------------------------------------------------------------
// cpt_checker
// Port-level checks of the checksummed parameter table, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input cpt_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input cpt_pkg::t_out o_out_data
);
    import cpt_pkg::*;

    // a stalled result holds
    `ASSERT_AT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "result changed under stall")

    // one command at a time: busy right after an accepted transaction
    `ASSERT_AT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "accepted while a command is in flight")

    // every error or check status carries zero data
    `ASSERT_NEVER(a_err_data_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_OK) && (o_out_data.read_data != 16'h0000), "nonzero data with error status")

    // a new result only comes out of a busy sequencer
    `ASSERT_AT(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result without a command in flight")

endmodule

bind checksummed_parameter_table_top cpt_checker u_cpt_checker (.*);

>>> sim/cpt_result_checker.sv
// ----------------------------------------------------------------------------
// cpt_result_checker
// Watches both channels of the parameter table, keeps a shadow copy of the
// store, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cpt_result_checker #(
    parameter int unsigned TABLE_DEPTH  = cpt_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned SUM_LOW_POS  = cpt_pkg::SUM_LOW_POS_DEF,
    parameter int unsigned SUM_HIGH_POS = cpt_pkg::SUM_HIGH_POS_DEF,
    parameter int unsigned CRC_POS      = cpt_pkg::CRC_POS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  cpt_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  cpt_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked,
    output int            o_range_seen,
    output int            o_sum_bad_seen,
    output int            o_crc_bad_seen
);
    import cpt_pkg::*;

    localparam logic [15:0] CRC_SEED           = 16'hFFFF;
    localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
    localparam int unsigned IMAGE_BYTES        = 39;

    // power-on parameter bytes, address 0 first
    localparam logic [8*IMAGE_BYTES-1:0] POWER_ON_IMAGE = {
        8'd58, 8'd55, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd1, 8'd0,
        8'd24, 8'd7, 8'd23, 8'd12, 8'd0, 8'd0,
        8'd1, 8'd40, 8'd0, 8'd0, 8'd0,
        8'd40, 8'd1, 8'd164, 8'd164, 8'd0, 8'd0, 8'd0, 8'd8,
        8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0
    };

    logic [7:0] shadow_table [0:255];
    t_out       expected_results [$];

    task automatic load_power_on();
        for (int i = 0; i < 256; i++) begin
            shadow_table[i] = (i < IMAGE_BYTES) ?
                POWER_ON_IMAGE[8*(IMAGE_BYTES-1-i) +: 8] : 8'h00;
        end
    endtask

    function automatic logic [15:0] wrapping_sum(input int unsigned len);
        logic [15:0] acc;
        acc = '0;
        for (int i = 0; i < len; i++) begin
            acc = acc + {8'h00, shadow_table[i]};
        end
        return acc;
    endfunction

    function automatic logic [15:0] modbus_crc(input int unsigned len);
        logic [15:0] crc;
        crc = CRC_SEED;
        for (int i = 0; i < len; i++) begin
            crc = crc ^ {8'h00, shadow_table[i]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_REFLECTED_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    // applies one command to the shadow store, returns the result it yields
    function automatic t_out table_step(input t_in cmd);
        t_out        r;
        logic [8:0]  upper;
        logic [15:0] s;
        logic [15:0] c;
        r = '0;
        upper = {1'b0, cmd.address} + 9'd1;
        case (cmd.kind)
            K_RD_BYTE: begin
                if (cmd.address < TABLE_DEPTH) r.read_data = {8'h00, shadow_table[cmd.address]};
                else r.status = ST_RANGE;
            end
            K_WR_BYTE: begin
                if (cmd.address < TABLE_DEPTH) shadow_table[cmd.address] = cmd.write_value[7:0];
                else r.status = ST_RANGE;
            end
            K_RD_HALF: begin
                if (upper < TABLE_DEPTH) begin
                    r.read_data = {shadow_table[upper[7:0]], shadow_table[cmd.address]};
                end else begin
                    r.status = ST_RANGE;
                end
            end
            K_WR_HALF: begin
                if (upper < TABLE_DEPTH) begin
                    shadow_table[cmd.address]  = cmd.write_value[7:0];
                    shadow_table[upper[7:0]]   = cmd.write_value[15:8];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            K_UPDATE: begin
                // sum goes in first, so the CRC covers it
                s = wrapping_sum(SUM_LOW_POS);
                shadow_table[SUM_LOW_POS]  = s[7:0];
                shadow_table[SUM_HIGH_POS] = s[15:8];
                c = modbus_crc(CRC_POS);
                shadow_table[CRC_POS] = c[7:0];
            end
            K_VERIFY: begin
                s = wrapping_sum(SUM_LOW_POS);
                if (s != {shadow_table[SUM_HIGH_POS], shadow_table[SUM_LOW_POS]}) begin
                    r.status = ST_SUM_BAD;
                end else begin
                    c = modbus_crc(CRC_POS);
                    if (c[7:0] != shadow_table[CRC_POS]) r.status = ST_CRC_BAD;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            load_power_on();
            expected_results.delete();
            o_fail_count   = 0;
            o_checked      = 0;
            o_range_seen   = 0;
            o_sum_bad_seen = 0;
            o_crc_bad_seen = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding",
                                    i_out_data.read_data, 16'h0000);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.read_data !== want.read_data)
                        report_mismatch("read_data", i_out_data.read_data, want.read_data);
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", {14'd0, i_out_data.status},
                                        {14'd0, want.status});
                    o_checked++;
                end
                case (i_out_data.status)
                    ST_RANGE:   o_range_seen++;
                    ST_SUM_BAD: o_sum_bad_seen++;
                    ST_CRC_BAD: o_crc_bad_seen++;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) expected_results.push_back(table_step(i_in_data));
        end
        o_pending = expected_results.size();
    end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the checksummed parameter table with directed and random command
// transactions under random idling and back-pressure; the result checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import cpt_pkg::*;

    localparam int unsigned ITEM_TARGET      = 1950;
    localparam int unsigned CYCLE_LIMIT      = 1_000_000;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    // longest command is a verify walk
    localparam int unsigned DRAIN_CYCLES     = 2 * (SUM_LOW_POS_DEF + CRC_POS_DEF);
    localparam int unsigned DEPTH            = TABLE_DEPTH_DEF;

    // kinds the block must ignore
    localparam logic [2:0] K_SPARE_LO = 3'd6;
    localparam logic [2:0] K_SPARE_HI = 3'd7;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    int fail_count;
    int pending;
    int checked;
    int range_seen;
    int sum_bad_seen;
    int crc_bad_seen;

    int unsigned items_sent  = 0;
    int unsigned walks_sent  = 0;
    int unsigned cycle_count = 0;
    bit          idle_on      = 1'b1;  // random gaps on both sides
    bit          hold_request = 1'b0;  // asks the receiver for one long hold

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    checksummed_parameter_table_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    cpt_result_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_range_seen   (range_seen),
        .o_sum_bad_seen (sum_bad_seen),
        .o_crc_bad_seen (crc_bad_seen)
    );

    // One command transaction. An optional idle burst comes first, so gaps
    // land right after a result as well as in the middle of a table walk.
    // Valid stays high and the payload stays put until the block takes it.
    task automatic send_cmd(input logic [2:0] kind, input logic [7:0] addr,
                            input logic [15:0] value);
        t_in cmd;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        cmd.kind        = kind;
        cmd.address     = addr;
        cmd.write_value = value;
        in_valid <= 1'b1;
        in_data  <= cmd;
        do @(posedge clk); while (in_stall);
        if (kind <= K_VERIFY) items_sent++;
        if (kind == K_UPDATE || kind == K_VERIFY) walks_sent++;
    endtask

    // Sender stops and waits for every outstanding result. The do-while
    // makes sure the checker has seen the last acceptance.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // mostly in-range addresses, now and then anything
    function automatic logic [7:0] pick_addr();
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, DEPTH - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_value();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Receiver: free-running stretches mix with random stall bursts.
    // A hold request gives one long stall counted here, while the sender
    // keeps offering, so the block backs up into its input.
    initial begin
        wait (rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("FAIL");
        $finish;
    end

    initial begin
        int unsigned pick;
        int unsigned n;
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        bit          hold_done;
        bit          pause_done;

        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // power-on table carries no sum yet: sum mismatch expected
        send_cmd(K_VERIFY, 8'd0, 16'h0000);
        // byte and halfword reads at both ends of the range and beyond
        send_cmd(K_RD_BYTE, 8'd0, 16'h0000);
        send_cmd(K_RD_BYTE, 8'(DEPTH - 1), 16'hFFFF);
        send_cmd(K_RD_BYTE, 8'(DEPTH), 16'h0000);
        send_cmd(K_RD_BYTE, 8'd255, 16'h0000);
        send_cmd(K_RD_HALF, 8'd0, 16'h0000);
        send_cmd(K_RD_HALF, 8'(DEPTH - 2), 16'h0000);
        send_cmd(K_RD_HALF, 8'(DEPTH - 1), 16'h0000);  // straddles the end
        send_cmd(K_RD_HALF, 8'd255, 16'h0000);
        // writes: last byte, out of range, only low byte used
        send_cmd(K_WR_BYTE, 8'(DEPTH - 1), 16'hFFFF);
        send_cmd(K_WR_BYTE, 8'(DEPTH), 16'h1234);
        send_cmd(K_WR_BYTE, 8'd0, 16'hFF00);
        send_cmd(K_WR_HALF, 8'(DEPTH - 2), 16'hABCD);
        send_cmd(K_WR_HALF, 8'(DEPTH - 1), 16'h5555);
        send_cmd(K_WR_HALF, 8'd0, 16'hFFFF);
        send_cmd(K_WR_HALF, 8'd40, 16'h0102);
        // protect, check, read the stored checks back
        send_cmd(K_UPDATE, 8'd0, 16'h0000);
        send_cmd(K_VERIFY, 8'd0, 16'h0000);
        send_cmd(K_RD_HALF, 8'(SUM_LOW_POS_DEF), 16'h0000);
        send_cmd(K_RD_BYTE, 8'(CRC_POS_DEF), 16'h0000);
        // swapped bytes keep the sum but break the CRC
        send_cmd(K_WR_HALF, 8'd40, 16'h0201);
        send_cmd(K_VERIFY, 8'd0, 16'h0000);
        // stored sum itself overwritten
        send_cmd(K_WR_BYTE, 8'(SUM_LOW_POS_DEF), 16'h00A5);
        send_cmd(K_VERIFY, 8'd0, 16'h0000);
        // unused kinds are ignored
        send_cmd(K_SPARE_LO, 8'd255, 16'hFFFF);
        send_cmd(K_SPARE_HI, 8'd0, 16'h0000);

        // ---- random part ----
        while (items_sent < ITEM_TARGET) begin
            // a quiet stretch mid-run and a quiet tail
            idle_on = (items_sent < 900 || items_sent > 1100) &&
                      (items_sent + 200 < ITEM_TARGET);

            if (!hold_done && items_sent >= 600) begin
                // receiver holds off while a burst of reads piles up
                hold_done    = 1'b1;
                hold_request = 1'b1;
                repeat (12) send_cmd(K_RD_BYTE, pick_addr(), pick_value());
            end
            if (!pause_done && items_sent >= 1200) begin
                pause_done = 1'b1;
                wait_all_results();
            end

            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // plain parameter access
                send_cmd(3'($urandom_range(K_RD_BYTE, K_WR_HALF)), pick_addr(), pick_value());
            end else if (pick < 70) begin
                // well-formed: edit, protect, maybe read, check
                n = $urandom_range(1, 4);
                repeat (n) begin
                    send_cmd($urandom_range(0, 1) ? K_WR_BYTE : K_WR_HALF,
                             8'($urandom_range(0, DEPTH - 2)), pick_value());
                end
                send_cmd(K_UPDATE, pick_addr(), pick_value());
                repeat ($urandom_range(0, 2))
                    send_cmd($urandom_range(0, 1) ? K_RD_BYTE : K_RD_HALF,
                             pick_addr(), pick_value());
                send_cmd(K_VERIFY, pick_addr(), pick_value());
            end else if (pick < 78) begin
                // byte swap inside the covered range: sum holds, CRC breaks
                a = 8'($urandom_range(0, SUM_LOW_POS_DEF - 2));
                x = 8'($urandom_range(0, 255));
                y = x ^ 8'($urandom_range(1, 255));
                send_cmd(K_WR_HALF, a, {y, x});
                send_cmd(K_UPDATE, pick_addr(), pick_value());
                send_cmd(K_WR_HALF, a, {x, y});
                send_cmd(K_VERIFY, pick_addr(), pick_value());
            end else if (pick < 84) begin
                // data or stored sum disturbed after protection
                send_cmd(K_UPDATE, pick_addr(), pick_value());
                send_cmd(K_WR_BYTE, 8'($urandom_range(0, SUM_HIGH_POS_DEF)), pick_value());
                send_cmd(K_VERIFY, pick_addr(), pick_value());
            end else if (pick < 88) begin
                // stored CRC byte disturbed
                send_cmd(K_UPDATE, pick_addr(), pick_value());
                send_cmd(K_WR_BYTE, 8'(CRC_POS_DEF), pick_value());
                send_cmd(K_VERIFY, pick_addr(), pick_value());
            end else if (pick < 91) begin
                send_cmd($urandom_range(0, 1) ? K_UPDATE : K_VERIFY, pick_addr(), pick_value());
            end else if (pick < 96) begin
                // at or past the end of the table
                send_cmd(3'($urandom_range(K_RD_BYTE, K_WR_HALF)),
                         8'($urandom_range(DEPTH - 1, 255)), pick_value());
            end else begin
                send_cmd($urandom_range(0, 1) ? K_SPARE_LO : K_SPARE_HI,
                         8'($urandom_range(0, 255)), pick_value());
            end
        end

        // ---- wind down ----
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands (%0d table walks), %0d results compared in %0d cycles",
                 items_sent, walks_sent, checked, cycle_count);
        $display("block reported %0d range errors, %0d sum and %0d crc mismatches; %0d errors",
                 range_seen, sum_bad_seen, crc_bad_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/cpt_pkg.sv
src/cpt_chk_unit.sv
src/checksummed_parameter_table_top.sv
src/cpt_checker.sv
sim/cpt_result_checker.sv
sim/tb.sv
